### src/mmd3_pkg.sv
package mmd3_pkg;

  localparam int WORD_BITS   = 32;
  localparam int STORE_WORDS = 32;
  localparam int ADDR_BITS   = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int LEN_BITS    = $clog2(STORE_WORDS + 1);

  typedef logic [WORD_BITS-1:0]   word_t;
  typedef logic [2*WORD_BITS-1:0] dword_t;
  typedef logic [ADDR_BITS-1:0]   addr_t;
  typedef logic [LEN_BITS-1:0]    len_t;

  // Reciprocal estimate of one third, scaled by two to the word size.
  localparam word_t RECIP3 = WORD_BITS'((64'd1 << WORD_BITS) / 3);

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_MUL  = 2'd1;
  localparam logic [1:0] CMD_DIV  = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  typedef logic [3:0] upc_t;

  localparam upc_t STEP_FETCH    = 4'd0;
  localparam upc_t STEP_LOAD     = 4'd1;
  localparam upc_t STEP_RD_ISSUE = 4'd2;
  localparam upc_t STEP_RD_TAKE  = 4'd3;
  localparam upc_t STEP_MUL_INIT = 4'd4;
  localparam upc_t STEP_MUL_LOOP = 4'd5;
  localparam upc_t STEP_MUL_TAIL = 4'd6;
  localparam upc_t STEP_DIV_INIT = 4'd7;
  localparam upc_t STEP_DIV_LOOP = 4'd8;
  localparam upc_t STEP_DIV_TAIL = 4'd9;
  localparam upc_t STEP_DONE     = 4'd10;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_FETCH,
    ACT_LOAD,
    ACT_RD_ISSUE,
    ACT_RD_TAKE,
    ACT_MUL_INIT,
    ACT_DIV_INIT,
    ACT_STREAM,
    ACT_MUL_TAIL,
    ACT_DIV_TAIL,
    ACT_DONE
  } act_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_GOTO,
    JMP_DISPATCH,
    JMP_STREAM,
    JMP_OUT_FREE
  } jmp_t;

  typedef struct packed {
    act_t act;
    jmp_t jmp;
    upc_t target;
  } ctrl_t;

  function automatic ctrl_t ucode(input upc_t step);
    ctrl_t c;
    c = '{act: ACT_NOP, jmp: JMP_GOTO, target: STEP_FETCH};
    case (step)
      STEP_FETCH:    c = '{act: ACT_FETCH,    jmp: JMP_DISPATCH, target: STEP_FETCH};
      STEP_LOAD:     c = '{act: ACT_LOAD,     jmp: JMP_GOTO,     target: STEP_DONE};
      STEP_RD_ISSUE: c = '{act: ACT_RD_ISSUE, jmp: JMP_NEXT,     target: STEP_FETCH};
      STEP_RD_TAKE:  c = '{act: ACT_RD_TAKE,  jmp: JMP_GOTO,     target: STEP_DONE};
      STEP_MUL_INIT: c = '{act: ACT_MUL_INIT, jmp: JMP_NEXT,     target: STEP_FETCH};
      STEP_MUL_LOOP: c = '{act: ACT_STREAM,   jmp: JMP_STREAM,   target: STEP_FETCH};
      STEP_MUL_TAIL: c = '{act: ACT_MUL_TAIL, jmp: JMP_GOTO,     target: STEP_DONE};
      STEP_DIV_INIT: c = '{act: ACT_DIV_INIT, jmp: JMP_NEXT,     target: STEP_FETCH};
      STEP_DIV_LOOP: c = '{act: ACT_STREAM,   jmp: JMP_STREAM,   target: STEP_FETCH};
      STEP_DIV_TAIL: c = '{act: ACT_DIV_TAIL, jmp: JMP_GOTO,     target: STEP_DONE};
      STEP_DONE:     c = '{act: ACT_DONE,     jmp: JMP_OUT_FREE, target: STEP_FETCH};
      default:       c = '{act: ACT_NOP,      jmp: JMP_GOTO,     target: STEP_FETCH};
    endcase
    return c;
  endfunction

  function automatic upc_t dispatch(input logic [1:0] cmd);
    upc_t s;
    case (cmd)
      CMD_LOAD: s = STEP_LOAD;
      CMD_MUL:  s = STEP_MUL_INIT;
      CMD_DIV:  s = STEP_DIV_INIT;
      CMD_READ: s = STEP_RD_ISSUE;
      default:  s = STEP_FETCH;
    endcase
    return s;
  endfunction

  // Contribution of the incoming remainder to the quotient estimate.
  function automatic word_t rem_recip(input logic [1:0] rem);
    word_t v;
    case (rem)
      2'd1:    v = RECIP3;
      2'd2:    v = WORD_BITS'({RECIP3, 1'b0});
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### src/mmd3_in_if.sv
interface mmd3_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] operand_word;
  logic [4:0]  word_index;

  modport source (output valid, command, operand_word, word_index, input ready);
  modport sink   (input valid, command, operand_word, word_index, output ready);
endinterface

### src/mmd3_out_if.sv
interface mmd3_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [1:0]  remainder;
  logic [31:0] read_data;
  logic [5:0]  used_count;

  modport source (output valid, ok, remainder, read_data, used_count, input ready);
  modport sink   (input valid, ok, remainder, read_data, used_count, output ready);
endinterface

### src/mmd3_ram.sv
module mmd3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/multiword_mul_div3_unit.sv
// Holds one little-endian unsigned number of up to STORE_WORDS words and works on it in
// place: load a word, multiply by a word, divide by three, or read a word. Each command gives
// exactly one result. A multiply or divide walks the n words of the number: the word loop
// streams one word per cycle through the single RAM read port and the one shared multiplier.
// A new command is taken while the previous result still waits.
module multiword_mul_div3_unit import mmd3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mmd3_in_if.sink     in_ch,
  mmd3_out_if.source  out_ch
);

  ctrl_t ctrl;
  upc_t  upc_r, upc_nxt;

  word_t  opw_r, opw_nxt;
  logic [4:0] idx_r, idx_nxt;
  len_t   n_r, n_nxt;
  word_t  mul_b_r, mul_b_nxt;
  logic   div_r, div_nxt;
  len_t   rcnt_r, rcnt_nxt;
  len_t   wcnt_r, wcnt_nxt;
  logic   v1_r, v1_nxt;
  logic   v2_r, v2_nxt;
  dword_t prod_r, prod_nxt;
  logic   lt3_r, lt3_nxt;
  logic [3:0] wlo_r, wlo_nxt;
  word_t  carry_r, carry_nxt;
  logic [1:0] rem_r, rem_nxt;
  logic   shrink_r, shrink_nxt;
  logic   hit_r, hit_nxt;
  logic   res_ok_r, res_ok_nxt;
  logic [1:0] res_rem_r, res_rem_nxt;
  word_t  res_rd_r, res_rd_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_ok_r, out_ok_nxt;
  logic [1:0] out_rem_r, out_rem_nxt;
  word_t  out_rd_r, out_rd_nxt;
  len_t   out_used_r, out_used_nxt;

  logic   ram_we;
  addr_t  ram_waddr, ram_raddr;
  word_t  ram_wdata, ram_q;

  logic   accept, out_free, stream_done;
  dword_t sum;
  word_t  q_est, q_fin;
  logic [3:0] r0, r1, r2;
  logic [1:0] corr;

  assign ctrl     = ucode(upc_r);
  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready       = (upc_r == STEP_FETCH);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.ok         = out_ok_r;
  assign out_ch.remainder  = out_rem_r;
  assign out_ch.read_data  = 32'(out_rd_r);
  assign out_ch.used_count = 6'(out_used_r);

  mmd3_ram #(.WIDTH(WORD_BITS), .DEPTH(STORE_WORDS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Multiply walks upward from word 0; divide walks downward from the top word.
  function automatic addr_t word_addr(input logic dn, input len_t len, input len_t k);
    len_t a;
    a = dn ? (len - k - LEN_BITS'(1)) : k;
    return ADDR_BITS'(a);
  endfunction

  // Stage three arithmetic, shared by both loops.
  always_comb begin
    sum   = prod_r + {{WORD_BITS{1'b0}}, carry_r};
    q_est = rem_recip(rem_r) + prod_r[2*WORD_BITS-1:WORD_BITS];
    // The true remainder of the estimate is below nine, so four low bits suffice.
    r0    = wlo_r - 4'(q_est[3:0] * 4'd3);
    r1    = (r0 >= 4'd3) ? r0 - 4'd3 : r0;
    r2    = (r1 >= 4'd3) ? r1 - 4'd3 : r1;
    corr  = {1'b0, r0 >= 4'd3} + {1'b0, r1 >= 4'd3};
    q_fin = q_est + WORD_BITS'(corr);
  end

  // Sequencer: next step.
  always_comb begin
    upc_nxt = upc_r;
    case (ctrl.jmp)
      JMP_NEXT:     upc_nxt = upc_r + upc_t'(1);
      JMP_GOTO:     upc_nxt = ctrl.target;
      JMP_DISPATCH: upc_nxt = accept ? dispatch(in_ch.command) : upc_r;
      JMP_STREAM:   upc_nxt = stream_done ? upc_r + upc_t'(1) : upc_r;
      JMP_OUT_FREE: upc_nxt = out_free ? ctrl.target : upc_r;
      default:      upc_nxt = STEP_FETCH;
    endcase
  end

  // Datapath controls for the current control word.
  always_comb begin
    opw_nxt       = opw_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    mul_b_nxt     = mul_b_r;
    div_nxt       = div_r;
    rcnt_nxt      = rcnt_r;
    wcnt_nxt      = wcnt_r;
    v1_nxt        = v1_r;
    v2_nxt        = v2_r;
    prod_nxt      = prod_r;
    lt3_nxt       = lt3_r;
    wlo_nxt       = wlo_r;
    carry_nxt     = carry_r;
    rem_nxt       = rem_r;
    shrink_nxt    = shrink_r;
    hit_nxt       = hit_r;
    res_ok_nxt    = res_ok_r;
    res_rem_nxt   = res_rem_r;
    res_rd_nxt    = res_rd_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ok_nxt    = out_ok_r;
    out_rem_nxt   = out_rem_r;
    out_rd_nxt    = out_rd_r;
    out_used_nxt  = out_used_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = word_addr(div_r, n_r, rcnt_r);
    stream_done   = 1'b0;

    case (ctrl.act)
      ACT_FETCH: begin
        if (accept) begin
          opw_nxt     = in_ch.operand_word[WORD_BITS-1:0];
          idx_nxt     = in_ch.word_index;
          res_ok_nxt  = 1'b1;
          res_rem_nxt = 2'd0;
          res_rd_nxt  = '0;
        end
      end
      ACT_LOAD: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = opw_r;
        n_nxt     = LEN_BITS'(1);
      end
      ACT_RD_ISSUE: begin
        ram_raddr = ADDR_BITS'(idx_r);
        hit_nxt   = (32'(idx_r) < 32'(n_r));
      end
      ACT_RD_TAKE: begin
        res_rd_nxt = hit_r ? ram_q : '0;
      end
      ACT_MUL_INIT, ACT_DIV_INIT: begin
        div_nxt    = (ctrl.act == ACT_DIV_INIT);
        mul_b_nxt  = (ctrl.act == ACT_DIV_INIT) ? RECIP3 : opw_r;
        rcnt_nxt   = '0;
        wcnt_nxt   = '0;
        v1_nxt     = 1'b0;
        v2_nxt     = 1'b0;
        carry_nxt  = '0;
        rem_nxt    = 2'd0;
        shrink_nxt = 1'b0;
      end
      ACT_STREAM: begin
        // Stage one: read request.
        v1_nxt   = (rcnt_r != n_r);
        rcnt_nxt = rcnt_r + LEN_BITS'(v1_nxt);
        // Stage two: multiply the word that came back from the store.
        v2_nxt   = v1_r;
        if (v1_r) begin
          prod_nxt = dword_t'(ram_q) * dword_t'(mul_b_r);
          lt3_nxt  = (ram_q < WORD_BITS'(3));
          wlo_nxt  = ram_q[3:0];
        end
        // Stage three: carry or remainder chain, then write back in place.
        if (v2_r) begin
          ram_we    = 1'b1;
          ram_waddr = word_addr(div_r, n_r, wcnt_r);
          if (div_r) begin
            ram_wdata = q_fin;
            rem_nxt   = r2[1:0];
            if (wcnt_r == '0) begin
              shrink_nxt = lt3_r;
            end
          end else begin
            ram_wdata = sum[WORD_BITS-1:0];
            carry_nxt = sum[2*WORD_BITS-1:WORD_BITS];
          end
          wcnt_nxt = wcnt_r + LEN_BITS'(1);
        end
        stream_done = (wcnt_nxt == n_r);
      end
      ACT_MUL_TAIL: begin
        if (carry_r != '0) begin
          if (n_r < LEN_BITS'(STORE_WORDS)) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_BITS'(n_r);
            ram_wdata = carry_r;
            n_nxt     = n_r + LEN_BITS'(1);
          end else begin
            res_ok_nxt = 1'b0;
          end
        end
      end
      ACT_DIV_TAIL: begin
        res_rem_nxt = rem_r;
        if (shrink_r) begin
          n_nxt = n_r - LEN_BITS'(1);
        end
      end
      ACT_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_rem_nxt   = res_rem_r;
          out_rd_nxt    = res_rd_r;
          out_used_nxt  = n_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= STEP_FETCH;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opw_r      <= opw_nxt;
    idx_r      <= idx_nxt;
    mul_b_r    <= mul_b_nxt;
    div_r      <= div_nxt;
    rcnt_r     <= rcnt_nxt;
    wcnt_r     <= wcnt_nxt;
    v1_r       <= v1_nxt;
    v2_r       <= v2_nxt;
    prod_r     <= prod_nxt;
    lt3_r      <= lt3_nxt;
    wlo_r      <= wlo_nxt;
    carry_r    <= carry_nxt;
    rem_r      <= rem_nxt;
    shrink_r   <= shrink_nxt;
    hit_r      <= hit_nxt;
    res_ok_r   <= res_ok_nxt;
    res_rem_r  <= res_rem_nxt;
    res_rd_r   <= res_rd_nxt;
    out_ok_r   <= out_ok_nxt;
    out_rem_r  <= out_rem_nxt;
    out_rd_r   <= out_rd_nxt;
    out_used_r <= out_used_nxt;
  end

endmodule

### verif/multiword_mul_div3_unit_test.sv
module multiword_mul_div3_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mmd3_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 50;
  localparam int SHOWN_ERRORS = 10;

  typedef struct packed {
    logic       ok;
    logic [1:0] remainder;
    word_t      read_data;
    len_t       used_count;
  } outcome_t;

  logic clk;
  logic rst_n;

  mmd3_in_if  in_ch();
  mmd3_out_if out_ch();

  multiword_mul_div3_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Mirror of the number held by the block.
  word_t number_words [STORE_WORDS];
  int    number_len;

  outcome_t expected_outcomes[$];
  int       error_count;
  int       items_sent;
  int       cycle_count;
  int       tx_idle_pct;
  int       rx_idle_pct;
  int       rx_hold_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic outcome_t apply_command(input logic [1:0] cmd, input word_t opw,
                                             input logic [4:0] idx);
    outcome_t res;
    dword_t   prod;
    dword_t   partial;
    word_t    carry;
    logic [1:0] rem;
    bit       shrink;
    res = '{ok: 1'b1, remainder: 2'd0, read_data: '0, used_count: '0};
    case (cmd)
      CMD_LOAD: begin
        number_words[0] = opw;
        number_len = 1;
      end
      CMD_MUL: begin
        carry = '0;
        for (int i = 0; i < number_len; i++) begin
          prod = dword_t'(number_words[i]) * dword_t'(opw) + dword_t'(carry);
          carry = prod[2*WORD_BITS-1:WORD_BITS];
          number_words[i] = prod[WORD_BITS-1:0];
        end
        if (carry != '0) begin
          if (number_len < STORE_WORDS) begin
            number_words[number_len] = carry;
            number_len++;
          end else begin
            res.ok = 1'b0;
          end
        end
      end
      CMD_DIV: begin
        if (number_len != 0) begin
          rem = 2'd0;
          shrink = number_words[number_len-1] < 3;
          for (int i = number_len - 1; i >= 0; i--) begin
            partial = (dword_t'(rem) << WORD_BITS) | dword_t'(number_words[i]);
            number_words[i] = word_t'(partial / 3);
            rem = 2'(partial % 3);
          end
          res.remainder = rem;
          if (shrink) number_len--;
        end
      end
      default: begin
        if (int'(idx) < number_len) res.read_data = number_words[idx];
      end
    endcase
    res.used_count = len_t'(number_len);
    return res;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= SHOWN_ERRORS) $display("%0t ns: %s", $realtime, msg);
  endtask

  // Sender: valid stays high across back-to-back transfers and drops only for a gap or at stop_sending.
  task automatic send_op(input logic [1:0] cmd, input word_t opw, input logic [4:0] idx);
    int gap;
    gap = 0;
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.operand_word <= opw;
    in_ch.word_index   <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_outcomes.push_back(apply_command(cmd, opw, idx));
    items_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_outcomes.size() != 0) @(posedge clk);
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(5))
      0:       return word_t'($urandom_range(3));
      1:       return word_t'(32'hFFFF_FFFF - $urandom_range(3));
      2:       return word_t'(32'h1 << $urandom_range(31));
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic logic [4:0] pick_index();
    if (number_len > 0 && $urandom_range(3) != 0) return 5'($urandom_range(number_len - 1));
    return 5'($urandom_range(31));
  endfunction

  // Result checker.
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_outcomes.size() == 0) begin
        flag_error($sformatf("result with nothing pending: ok %0d rem %0d data %h len %0d",
                             out_ch.ok, out_ch.remainder, out_ch.read_data, out_ch.used_count));
      end else begin
        want = expected_outcomes.pop_front();
        if (out_ch.ok !== want.ok)
          flag_error($sformatf("ok: expected %0d, got %0d", want.ok, out_ch.ok));
        if (out_ch.remainder !== want.remainder)
          flag_error($sformatf("remainder: expected %0d, got %0d",
                               want.remainder, out_ch.remainder));
        if (out_ch.read_data !== want.read_data)
          flag_error($sformatf("read_data: expected %h, got %h",
                               want.read_data, out_ch.read_data));
        if (out_ch.used_count !== want.used_count)
          flag_error($sformatf("used_count: expected %0d, got %0d",
                               want.used_count, out_ch.used_count));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic test_directed_cases();
    tx_idle_pct = 20;
    rx_idle_pct = 40;
    // Empty number: divide, multiply and reads all leave it empty.
    send_op(CMD_DIV, 32'h0, 5'd0);
    send_op(CMD_MUL, 32'hFFFF_FFFF, 5'd0);
    send_op(CMD_READ, 32'h0, 5'd0);
    send_op(CMD_READ, 32'hFFFF_FFFF, 5'd31);
    // Carry appended as a new top word, then reads inside and past the length.
    send_op(CMD_LOAD, 32'hFFFF_FFFF, 5'd31);
    send_op(CMD_MUL, 32'hFFFF_FFFF, 5'd0);
    send_op(CMD_READ, 32'h0, 5'd0);
    send_op(CMD_READ, 32'h0, 5'd1);
    send_op(CMD_READ, 32'h0, 5'd2);
    send_op(CMD_DIV, 32'h0, 5'd0);
    send_op(CMD_READ, 32'h0, 5'd1);
    // Zero multiplier clears the words; the zero top word then shrinks on divide.
    send_op(CMD_MUL, 32'h0, 5'd0);
    send_op(CMD_DIV, 32'h0, 5'd0);
    send_op(CMD_DIV, 32'h0, 5'd0);
    send_op(CMD_DIV, 32'h0, 5'd0);
    // Top word below three with remainder two.
    send_op(CMD_LOAD, 32'h2, 5'd0);
    send_op(CMD_DIV, 32'h0, 5'd0);
    send_op(CMD_LOAD, 32'h1, 5'd0);
    send_op(CMD_MUL, 32'h1, 5'd0);
    send_op(CMD_MUL, 32'h8000_0000, 5'd0);
    send_op(CMD_MUL, 32'h3, 5'd0);
    send_op(CMD_DIV, 32'h0, 5'd0);
    send_op(CMD_READ, 32'h0, 5'd1);
    send_op(CMD_LOAD, 32'h5555_5556, 5'd0);
    send_op(CMD_DIV, 32'h0, 5'd0);
    stop_sending();
  endtask

  task automatic test_capacity_overflow();
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    send_op(CMD_LOAD, 32'hFFFF_FFFF, 5'd0);
    while (number_len < STORE_WORDS) send_op(CMD_MUL, 32'hFFFF_FFFF, 5'd0);
    send_op(CMD_READ, 32'h0, 5'd31);
    // Carry out of a full number: low words updated, length kept, ok low.
    send_op(CMD_MUL, 32'hFFFF_FFFF, 5'd0);
    send_op(CMD_READ, 32'h0, 5'd31);
    send_op(CMD_READ, 32'h0, 5'd0);
    send_op(CMD_MUL, 32'h1, 5'd0);
    send_op(CMD_DIV, 32'h0, 5'd0);
    send_op(CMD_READ, 32'h0, 5'd30);
    stop_sending();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_left = 300;
    send_op(CMD_LOAD, pick_word(), 5'd0);
    repeat (6) send_op(CMD_MUL, word_t'($urandom), 5'd0);
    repeat (3) send_op(CMD_READ, 32'h0, pick_index());
    send_op(CMD_DIV, 32'h0, 5'd0);
    send_op(CMD_LOAD, 32'h7, 5'd0);
    send_op(CMD_READ, 32'h0, 5'd0);
    stop_sending();
    wait_drained();
  endtask

  // One random sequence: mostly a load followed by arithmetic and reads,
  // sometimes a long run of large multipliers to reach capacity, sometimes noise.
  task automatic run_sequence();
    int steps;
    int pick;
    int style;
    style = $urandom_range(9);
    if (style != 0) send_op(CMD_LOAD, pick_word(), 5'($urandom));
    if (style < 2) begin
      steps = $urandom_range(40, 28);
      repeat (steps) begin
        if ($urandom_range(4) == 0) send_op(CMD_READ, 32'($urandom), pick_index());
        else send_op(CMD_MUL, word_t'($urandom) | 32'h8000_0000, 5'($urandom));
      end
      send_op(CMD_DIV, 32'($urandom), 5'($urandom));
    end else begin
      steps = $urandom_range(45, 1);
      repeat (steps) begin
        pick = $urandom_range(99);
        if (pick < 45) send_op(CMD_MUL, pick_word(), 5'($urandom));
        else if (pick < 62) send_op(CMD_DIV, 32'($urandom), 5'($urandom));
        else if (pick < 95) send_op(CMD_READ, 32'($urandom), pick_index());
        else send_op(CMD_LOAD, pick_word(), 5'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
    int goal;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    goal = items_sent + count;
    while (items_sent < goal) run_sequence();
    stop_sending();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_LOAD;
    in_ch.operand_word = '0;
    in_ch.word_index   = '0;
    error_count        = 0;
    items_sent         = 0;
    tx_idle_pct        = 0;
    rx_idle_pct        = 0;
    rx_hold_left       = 0;
    number_len         = 0;
    foreach (number_words[i]) number_words[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_capacity_overflow();
    test_backpressure();
    test_random_traffic(31, 61, 440);
    test_random_traffic(61, 31, 440);
    test_random_traffic(0, 0, 440);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_outcomes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
